[rtl/core/sspd_pkg.sv]
`timescale 1ns / 1ps
// Package for the stereo SAD subpixel depth block.
// Holds payload structs, operation and register codes, state type and divider widths.
package sspd_pkg;

    // Input operation codes
    localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASELINE_FOCAL = 2'd0;
    localparam logic [1:0] CFG_MAX_DISPARITY  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [23:0] BASELINE_FOCAL_RST = 24'd41532;
    localparam logic [13:0] MAX_DISPARITY_RST  = 14'd5584;
    localparam logic [9:0]  IMAGE_WIDTH_RST    = 10'd432;

    // Shared divider widths (cover the depth division and the parabola offset)
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 24;

    // Largest depth, refined column and best SAD that can be reported
    localparam logic [23:0] DEPTH_MAX = 24'hFFFFFF;
    localparam logic [17:0] FINE_MAX  = 18'h3FFFF;
    localparam logic [15:0] SAD_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  pixel;
        logic [13:0] left_x;
        logic [13:0] coarse_right_x;
    } in_t;

    typedef struct packed {
        logic        match_valid;
        logic [23:0] depth_mm;
        logic [17:0] right_x_fine;
        logic [15:0] best_sad;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CENTER,
        S_CLATCH,
        S_SAD,
        S_SAVE,
        S_EVAL,
        S_PDIV,
        S_FINE,
        S_DDIV,
        S_OUT
    } state_t;

endpackage

[rtl/core/sspd_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sspd_pkg for the operand widths.
module sspd_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sspd_pkg::DIV_NW-1:0]  num,
    input  logic [sspd_pkg::DIV_DW-1:0]  den,
    output logic                         busy,
    output logic                         done,
    output logic [sspd_pkg::DIV_NW-1:0]  quot
);

    localparam int NW  = sspd_pkg::DIV_NW;
    localparam int DW  = sspd_pkg::DIV_DW;
    localparam int CW  = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    // One shift-subtract step per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without a running division");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0)) else $error("divider count ran out while busy");
`endif

endmodule

[rtl/core/stereo_sad_subpixel_depth.sv]
`timescale 1ns / 1ps
// Stereo keypoint SAD search with parabola subpixel fit and depth division.
// A compute holds off input until the result is registered; the search runs on one
// abs-diff accumulator visiting each pixel pair and a shared 34-step divider.
// rst_n clears control, patch memories are not cleared.
module stereo_sad_subpixel_depth
#(
    parameter int HALF_WINDOW   = 5,
    parameter int SEARCH_RADIUS = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sspd_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output sspd_pkg::out_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [23:0]     cfg_data
);

    localparam int PS     = 2 * HALF_WINDOW + 1;
    localparam int SW     = PS + 2 * SEARCH_RADIUS;
    localparam int LS     = PS * PS;
    localparam int RS     = PS * SW;
    localparam int SC     = 2 * SEARCH_RADIUS + 1;
    localparam int LA_W   = $clog2(LS);
    localparam int RA_W   = $clog2(RS);
    localparam int CNT_W  = $clog2(LS + 1);
    localparam int COL_W  = $clog2(PS);
    localparam int IDX_W  = $clog2(SC);
    localparam int SAD_W  = $clog2(LS * 510 + 1);
    localparam int LC_ADDR = HALF_WINDOW * PS + HALF_WINDOW;
    localparam int RC_ADDR = HALF_WINDOW * SW + HALF_WINDOW;
    localparam int LO_OFS = 16 * (SEARCH_RADIUS - HALF_WINDOW);
    localparam int HI_OFS = 16 * (SEARCH_RADIUS + HALF_WINDOW + 1);

    sspd_pkg::state_t state_reg, state_next;

    // Configuration
    logic [23:0] bf_reg;
    logic [13:0] maxd_reg;
    logic [9:0]  iw_reg;

    // Patch memories
    logic [7:0] left_mem  [LS];
    logic [7:0] right_mem [RS];
    logic [LA_W-1:0] lidx_reg, lidx_next;
    logic [RA_W-1:0] ridx_reg, ridx_next;
    logic [LA_W-1:0] l_rd_addr;
    logic [RA_W-1:0] r_rd_addr;
    logic [7:0]      l_rd_reg, r_rd_reg;
    logic            in_acc;
    logic            wr_left, wr_right;

    // Sequencer state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LA_W-1:0]  la_reg, la_next;
    logic [RA_W-1:0]  ra_reg, ra_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] shift_reg, shift_next;
    logic [SAD_W-1:0] acc_reg, acc_next;
    logic [7:0]       lc_reg, lc_next, rc_reg, rc_next;
    logic [SAD_W-1:0] best_reg, best_next, d1_reg, d1_next, d3_reg, d3_next;
    logic [SAD_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] bidx_reg, bidx_next;
    logic             cap_reg, cap_next;
    logic             neg_reg, neg_next;
    logic [13:0]      cr_reg, cr_next, lx_reg, lx_next;
    logic signed [21:0] fine_reg, fine_next;
    sspd_pkg::out_t   res_reg, res_next;
    sspd_pkg::out_t   out_reg, out_next;
    logic             ov_reg, ov_next;

    // Shared divider
    logic                        div_start, div_busy, div_done;
    logic [sspd_pkg::DIV_NW-1:0] div_num, div_quot;
    logic [sspd_pkg::DIV_DW-1:0] div_den;

    // Combinational helpers
    logic signed [17:0] lo_pos, hi_pos, width16;
    logic signed [9:0]  da, db;
    logic signed [10:0] dd;
    logic [9:0]         absd;
    logic signed [SAD_W+2:0] den_s;
    logic [SAD_W-1:0]   dmag;
    logic signed [21:0] cr16, lx16, shift_ofs, delta, disp_c, maxd16;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != sspd_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign wr_left   = in_acc && (in_data.operation == sspd_pkg::OP_LOAD_LEFT);
    assign wr_right  = in_acc && (in_data.operation == sspd_pkg::OP_LOAD_RIGHT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bf_reg   <= sspd_pkg::BASELINE_FOCAL_RST;
            maxd_reg <= sspd_pkg::MAX_DISPARITY_RST;
            iw_reg   <= sspd_pkg::IMAGE_WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sspd_pkg::CFG_BASELINE_FOCAL: bf_reg   <= cfg_data;
                sspd_pkg::CFG_MAX_DISPARITY:  maxd_reg <= cfg_data[13:0];
                sspd_pkg::CFG_IMAGE_WIDTH:    iw_reg   <= cfg_data[9:0];
                default:                      ;
            endcase
        end
    end

    // Patch memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (wr_left)
            left_mem[lidx_reg] <= in_data.pixel;
        l_rd_reg <= left_mem[l_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_right)
            right_mem[ridx_reg] <= in_data.pixel;
        r_rd_reg <= right_mem[r_rd_addr];
    end

    // Read address: centre pixels in S_CENTER, running window otherwise
    always_comb
    begin
        if (state_reg == sspd_pkg::S_CENTER)
        begin
            l_rd_addr = LA_W'(LC_ADDR);
            r_rd_addr = RA_W'(RC_ADDR) + RA_W'(shift_reg);
        end
        else
        begin
            l_rd_addr = la_reg;
            r_rd_addr = ra_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sspd_pkg::S_IDLE;
            lidx_reg  <= '0;
            ridx_reg  <= '0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            bidx_reg  <= '0;
            cap_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lidx_reg  <= lidx_next;
            ridx_reg  <= ridx_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            bidx_reg  <= bidx_next;
            cap_reg   <= cap_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        la_reg   <= la_next;
        ra_reg   <= ra_next;
        col_reg  <= col_next;
        acc_reg  <= acc_next;
        lc_reg   <= lc_next;
        rc_reg   <= rc_next;
        best_reg <= best_next;
        d1_reg   <= d1_next;
        d3_reg   <= d3_next;
        prev_reg <= prev_next;
        neg_reg  <= neg_next;
        cr_reg   <= cr_next;
        lx_reg   <= lx_next;
        fine_reg <= fine_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Arithmetic shared by the sequencer states
    always_comb
    begin
        lo_pos    = $signed({4'b0, cr_reg}) + 18'(LO_OFS);
        hi_pos    = $signed({4'b0, cr_reg}) + 18'(HI_OFS);
        width16   = $signed({4'b0, iw_reg, 4'b0});
        da        = $signed({2'b0, l_rd_reg}) - $signed({2'b0, lc_reg});
        db        = $signed({2'b0, r_rd_reg}) - $signed({2'b0, rc_reg});
        dd        = 11'(da) - 11'(db);
        absd      = dd[10] ? 10'(-dd) : 10'(dd);
        den_s     = $signed({3'b0, d1_reg}) + $signed({3'b0, d3_reg})
                    - $signed({2'b0, best_reg, 1'b0});
        dmag      = (d1_reg >= d3_reg) ? (d1_reg - d3_reg) : (d3_reg - d1_reg);
        cr16      = $signed({4'b0, cr_reg, 4'b0});
        lx16      = $signed({4'b0, lx_reg, 4'b0});
        shift_ofs = (22'(bidx_reg) - 22'(SEARCH_RADIUS)) <<< 8;
        delta     = neg_reg ? -$signed({12'b0, div_quot[9:0]})
                            : $signed({12'b0, div_quot[9:0]});
        disp_c    = lx16 - fine_reg;
        maxd16    = $signed({4'b0, maxd_reg, 4'b0});
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        lidx_next  = lidx_reg;
        ridx_next  = ridx_reg;
        cnt_next   = cnt_reg;
        la_next    = la_reg;
        ra_next    = ra_reg;
        col_next   = col_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        lc_next    = lc_reg;
        rc_next    = rc_reg;
        best_next  = best_reg;
        d1_next    = d1_reg;
        d3_next    = d3_reg;
        prev_next  = prev_reg;
        bidx_next  = bidx_reg;
        cap_next   = cap_reg;
        neg_next   = neg_reg;
        cr_next    = cr_reg;
        lx_next    = lx_reg;
        fine_next  = fine_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;

        // Output register drains independently
        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (state_reg)
            sspd_pkg::S_IDLE:
            begin
                if (wr_left)
                    lidx_next = (lidx_reg == LA_W'(LS - 1)) ? '0 : lidx_reg + 1'b1;
                if (wr_right)
                    ridx_next = (ridx_reg == RA_W'(RS - 1)) ? '0 : ridx_reg + 1'b1;
                if (in_acc && in_data.operation == sspd_pkg::OP_COMPUTE)
                begin
                    lidx_next  = '0;
                    ridx_next  = '0;
                    cr_next    = in_data.coarse_right_x;
                    lx_next    = in_data.left_x;
                    state_next = sspd_pkg::S_CHECK;
                end
            end

            // Window bound check against the image width
            sspd_pkg::S_CHECK:
            begin
                res_next   = '0;
                shift_next = '0;
                best_next  = '1;
                bidx_next  = '0;
                cap_next   = 1'b0;
                if (lo_pos < 0 || hi_pos >= width16)
                    state_next = sspd_pkg::S_OUT;
                else
                    state_next = sspd_pkg::S_CENTER;
            end

            // Centre reads issue; window counters start
            sspd_pkg::S_CENTER:
            begin
                la_next    = '0;
                ra_next    = RA_W'(shift_reg);
                col_next   = '0;
                acc_next   = '0;
                state_next = sspd_pkg::S_CLATCH;
            end

            // Centres arrive; first pixel pair issues
            sspd_pkg::S_CLATCH:
            begin
                lc_next    = l_rd_reg;
                rc_next    = r_rd_reg;
                la_next    = la_reg + 1'b1;
                if (col_reg == COL_W'(PS - 1))
                begin
                    col_next = '0;
                    ra_next  = ra_reg + RA_W'(SW - PS + 1);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    ra_next  = ra_reg + 1'b1;
                end
                cnt_next   = CNT_W'(1);
                state_next = sspd_pkg::S_SAD;
            end

            // Accumulate one pair, issue the next
            sspd_pkg::S_SAD:
            begin
                acc_next = acc_reg + SAD_W'(absd);
                if (cnt_reg == CNT_W'(LS))
                    state_next = sspd_pkg::S_SAVE;
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    la_next  = la_reg + 1'b1;
                    if (col_reg == COL_W'(PS - 1))
                    begin
                        col_next = '0;
                        ra_next  = ra_reg + RA_W'(SW - PS + 1);
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        ra_next  = ra_reg + 1'b1;
                    end
                end
            end

            // Track the first minimum and its two neighbors
            sspd_pkg::S_SAVE:
            begin
                prev_next = acc_reg;
                if (acc_reg < best_reg)
                begin
                    best_next = acc_reg;
                    bidx_next = shift_reg;
                    d1_next   = prev_reg;
                    cap_next  = 1'b1;
                end
                else if (cap_reg)
                begin
                    d3_next  = acc_reg;
                    cap_next = 1'b0;
                end
                if (shift_reg == IDX_W'(SC - 1))
                    state_next = sspd_pkg::S_EVAL;
                else
                begin
                    shift_next = shift_reg + 1'b1;
                    state_next = sspd_pkg::S_CENTER;
                end
            end

            // Report best SAD, reject end shifts and non-positive curvature, start the parabola division
            sspd_pkg::S_EVAL:
            begin
                res_next.best_sad = (best_reg > SAD_W'(sspd_pkg::SAD_MAX))
                                    ? sspd_pkg::SAD_MAX : 16'(best_reg);
                neg_next = (d1_reg < d3_reg);
                if (bidx_reg == '0 || bidx_reg == IDX_W'(SC - 1) || den_s <= 0)
                    state_next = sspd_pkg::S_OUT;
                else
                begin
                    div_start  = 1'b1;
                    div_num    = sspd_pkg::DIV_NW'({dmag, 7'b0})
                                 + sspd_pkg::DIV_NW'(den_s[SAD_W+2:1]);
                    div_den    = sspd_pkg::DIV_DW'(den_s);
                    state_next = sspd_pkg::S_PDIV;
                end
            end

            // Offset ready: bound it and form the refined column
            sspd_pkg::S_PDIV:
            begin
                if (div_done)
                begin
                    if (div_quot > sspd_pkg::DIV_NW'(256))
                        state_next = sspd_pkg::S_OUT;
                    else
                    begin
                        fine_next  = cr16 + shift_ofs + delta;
                        state_next = sspd_pkg::S_FINE;
                    end
                end
            end

            // Disparity bound, zero disparity forced to one LSB, depth division
            sspd_pkg::S_FINE:
            begin
                if (disp_c < 0 || disp_c >= maxd16)
                    state_next = sspd_pkg::S_OUT;
                else
                begin
                    if (disp_c == 0)
                    begin
                        fine_next = lx16 - 22'sd1;
                        div_num   = sspd_pkg::DIV_NW'({bf_reg, 8'b0});
                        div_den   = sspd_pkg::DIV_DW'(1);
                    end
                    else
                    begin
                        div_num   = sspd_pkg::DIV_NW'({bf_reg, 8'b0})
                                    + sspd_pkg::DIV_NW'(disp_c[21:1]);
                        div_den   = sspd_pkg::DIV_DW'(disp_c);
                    end
                    div_start  = 1'b1;
                    state_next = sspd_pkg::S_DDIV;
                end
            end

            // Depth ready: saturate and clamp
            sspd_pkg::S_DDIV:
            begin
                if (div_done)
                begin
                    res_next.match_valid = 1'b1;
                    res_next.depth_mm    = (div_quot > sspd_pkg::DIV_NW'(sspd_pkg::DEPTH_MAX))
                                           ? sspd_pkg::DEPTH_MAX : div_quot[23:0];
                    if (fine_reg < 0)
                        res_next.right_x_fine = '0;
                    else if (fine_reg > $signed({4'b0, sspd_pkg::FINE_MAX}))
                        res_next.right_x_fine = sspd_pkg::FINE_MAX;
                    else
                        res_next.right_x_fine = fine_reg[17:0];
                    state_next = sspd_pkg::S_OUT;
                end
            end

            // Hand the result to the output register once it is free
            sspd_pkg::S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    out_next   = res_reg;
                    ov_next    = 1'b1;
                    state_next = sspd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sspd_pkg::S_IDLE;
            end
        endcase
    end

    sspd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_reg.match_valid) |->
        (out_reg.depth_mm == '0 && out_reg.right_x_fine == '0))
        else $error("rejected match carries depth or column");
    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sspd_pkg::S_PDIV || state_reg == sspd_pkg::S_DDIV) |->
        (div_busy || div_done)) else $error("waiting on an idle divider");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LS)) else $error("pixel counter past window");
    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bidx_reg <= IDX_W'(SC - 1)) else $error("best shift index out of range");
`endif

endmodule
